/* src/all_pairs_shortest_path_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ALL_PAIRS_SHORTEST_PATH_MACROS_SVH
`define ALL_PAIRS_SHORTEST_PATH_MACROS_SVH

// Same-cycle implication.
`define APSP_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define APSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/apsp_pkg.sv */
package apsp_pkg;

   localparam int MAX_NODES       = 8;
   localparam int DIST_BITS       = 16;
   localparam int WEIGHT_BITS     = 16;
   localparam int OUT_DIST_BITS   = 16;
   localparam int NODE_FIELD_BITS = 3;
   localparam int CFG_BITS        = 4;

   localparam int IDX_BITS   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_BITS   = $clog2(MAX_NODES + 1);
   localparam int ADDR_BITS  = 2 * IDX_BITS;
   localparam int CELL_DEPTH = 1 << ADDR_BITS;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CFG_BITS-1:0] NODE_COUNT_RESET = 4'd8;

   localparam logic signed [63:0] DIST_MAX_WIDE = (64'sd1 <<< (DIST_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] DIST_MIN_WIDE = -(64'sd1 <<< (DIST_BITS - 1));

   typedef logic [IDX_BITS-1:0]         idx_type;
   typedef logic [CNT_BITS-1:0]         cnt_type;
   typedef logic [ADDR_BITS-1:0]        addr_type;
   typedef logic signed [DIST_BITS-1:0] dist_type;

   typedef struct packed {
      logic signed [WEIGHT_BITS-1:0] weight;
      logic                          no_edge;
   } req_type;

   typedef struct packed {
      logic signed [OUT_DIST_BITS-1:0] distance;
      logic                            unreachable;
      logic [NODE_FIELD_BITS-1:0]      from_node;
      logic [NODE_FIELD_BITS-1:0]      to_node;
      logic                            final_entry;
   } rsp_type;

   typedef struct packed {
      dist_type len;
      logic     reach;
   } cell_type;

   typedef struct packed {
      addr_type addr;
      cell_type payload;
      logic     last;
   } entry_type;

   typedef struct packed {
      cnt_type nodes;
   } ctrl_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_RELAX_RD,
      ST_RELAX_SUM,
      ST_RELAX_UPD,
      ST_OUT_RD,
      ST_OUT_LD
   } back_state_type;

   function automatic dist_type sat_weight(logic signed [WEIGHT_BITS-1:0] w);
      logic signed [63:0] wide;
      wide = 64'(w);
      if (wide > DIST_MAX_WIDE) begin
         wide = DIST_MAX_WIDE;
      end else if (wide < DIST_MIN_WIDE) begin
         wide = DIST_MIN_WIDE;
      end
      return DIST_BITS'(wide);
   endfunction

   function automatic dist_type sat_sum(dist_type a, dist_type b);
      logic [DIST_BITS:0] s;
      dist_type           r;
      s = {a[DIST_BITS-1], a} + {b[DIST_BITS-1], b};
      if (s[DIST_BITS] != s[DIST_BITS-1]) begin
         r = s[DIST_BITS] ? {1'b1, {(DIST_BITS-1){1'b0}}} : {1'b0, {(DIST_BITS-1){1'b1}}};
      end else begin
         r = s[DIST_BITS-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [OUT_DIST_BITS-1:0] out_dist(dist_type d);
      logic signed [63:0] wide;
      wide = 64'(d);
      return wide[OUT_DIST_BITS-1:0];
   endfunction

endpackage

/* src/apsp_ram.sv */
module apsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

/* src/apsp_front.sv */
module apsp_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  apsp_pkg::req_type                 req_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [apsp_pkg::CFG_BITS-1:0]     csr_data,
   output logic                              q_push,
   output apsp_pkg::entry_type               q_entry,
   input  logic                              q_full,
   output apsp_pkg::ctrl_type                ctrl
);

   logic [apsp_pkg::CFG_BITS-1:0] node_count_ff, node_count_in;
   apsp_pkg::idx_type             row_ff, row_in;
   apsp_pkg::idx_type             col_ff, col_in;
   apsp_pkg::cnt_type             nodes;
   apsp_pkg::cnt_type             last_idx;
   logic                          last_col;
   logic                          last_row;

   always_comb begin
      if (node_count_ff == '0) begin
         nodes = apsp_pkg::CNT_BITS'(1);
      end else if (node_count_ff > apsp_pkg::CFG_BITS'(apsp_pkg::MAX_NODES)) begin
         nodes = apsp_pkg::CNT_BITS'(apsp_pkg::MAX_NODES);
      end else begin
         nodes = apsp_pkg::CNT_BITS'(node_count_ff);
      end
   end

   assign last_idx   = nodes - apsp_pkg::CNT_BITS'(1);
   assign last_col   = apsp_pkg::CNT_BITS'(col_ff) == last_idx;
   assign last_row   = apsp_pkg::CNT_BITS'(row_ff) == last_idx;
   assign ctrl.nodes = nodes;

   assign csr_ready = 1'b1;
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   assign q_entry.addr          = {row_ff, col_ff};
   assign q_entry.payload.len   = apsp_pkg::sat_weight(req_data.weight);
   assign q_entry.payload.reach = !req_data.no_edge;
   assign q_entry.last          = last_row && last_col;

   always_comb begin
      node_count_in = node_count_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      if (csr_valid) begin
         // restart the load position on every register write
         node_count_in = csr_data;
         row_in        = '0;
         col_in        = '0;
      end else if (q_push) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + apsp_pkg::IDX_BITS'(1);
         end else begin
            col_in = col_ff + apsp_pkg::IDX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= apsp_pkg::NODE_COUNT_RESET;
         row_ff        <= '0;
         col_ff        <= '0;
      end else begin
         node_count_ff <= node_count_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
      end
   end

endmodule

/* src/apsp_queue.sv */
`include "all_pairs_shortest_path_macros.svh"

module apsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  apsp_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output apsp_pkg::entry_type pop_entry,
   output logic                empty
);

   apsp_pkg::entry_type              slots_ff [apsp_pkg::QUEUE_DEPTH];
   logic [apsp_pkg::QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [apsp_pkg::QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [apsp_pkg::QCNT_BITS-1:0]   count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full      = count_ff == apsp_pkg::QCNT_BITS'(apsp_pkg::QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == apsp_pkg::QPTR_BITS'(apsp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + apsp_pkg::QPTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == apsp_pkg::QPTR_BITS'(apsp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + apsp_pkg::QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + apsp_pkg::QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - apsp_pkg::QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `APSP_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= apsp_pkg::QCNT_BITS'(apsp_pkg::QUEUE_DEPTH), "queue count above depth")
   `APSP_ASSERT_NEXT(a_push_lands, clock, reset, do_push && !do_pop, count_ff == $past(count_ff) + apsp_pkg::QCNT_BITS'(1), "push did not grow the queue")
   `APSP_ASSERT_IMPLIES(a_ptr_match, clock, reset, empty || full, wr_ptr_ff == rd_ptr_ff, "pointers disagree with count")

endmodule

/* src/apsp_back.sv */
`include "all_pairs_shortest_path_macros.svh"

module apsp_back (
   input  logic                clock,
   input  logic                reset,
   input  apsp_pkg::ctrl_type  ctrl,
   input  logic                q_empty,
   input  apsp_pkg::entry_type q_entry,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output apsp_pkg::rsp_type   rsp_data
);

   apsp_pkg::back_state_type state_ff, state_in;
   apsp_pkg::idx_type        i_ff, i_in;
   apsp_pkg::idx_type        j_ff, j_in;
   apsp_pkg::idx_type        k_ff, k_in;
   apsp_pkg::dist_type       sum_ff, sum_in;
   logic                     skip_ff, skip_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   apsp_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic                                      wr_en;
   apsp_pkg::addr_type                        wr_addr;
   apsp_pkg::cell_type                        wr_cell;
   apsp_pkg::addr_type                        rd_addr_a;
   apsp_pkg::addr_type                        rd_addr_b;
   logic [$bits(apsp_pkg::cell_type)-1:0]     rd_raw_a;
   logic [$bits(apsp_pkg::cell_type)-1:0]     rd_raw_b;
   apsp_pkg::cell_type                        cell_a;
   apsp_pkg::cell_type                        cell_b;

   apsp_pkg::cnt_type last_idx;
   logic              last_i;
   logic              last_j;
   logic              last_k;
   logic              out_free;

   assign cell_a   = apsp_pkg::cell_type'(rd_raw_a);
   assign cell_b   = apsp_pkg::cell_type'(rd_raw_b);
   assign last_idx = ctrl.nodes - apsp_pkg::CNT_BITS'(1);
   assign last_i   = apsp_pkg::CNT_BITS'(i_ff) == last_idx;
   assign last_j   = apsp_pkg::CNT_BITS'(j_ff) == last_idx;
   assign last_k   = apsp_pkg::CNT_BITS'(k_ff) == last_idx;
   assign out_free = !rsp_valid_ff || rsp_ready;

   apsp_ram #(
      .WIDTH ($bits(apsp_pkg::cell_type)),
      .DEPTH (apsp_pkg::CELL_DEPTH)
   ) u_matrix (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_cell),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_raw_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_raw_b)
   );

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      sum_in       = sum_ff;
      skip_in      = skip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = {i_ff, j_ff};
      wr_cell      = '{len: sum_ff, reach: 1'b1};
      rd_addr_a    = {i_ff, j_ff};
      rd_addr_b    = {k_ff, j_ff};

      unique case (state_ff)
         apsp_pkg::ST_LOAD: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               wr_en   = 1'b1;
               wr_addr = q_entry.addr;
               wr_cell = q_entry.payload;
               if (q_entry.last) begin
                  i_in     = '0;
                  j_in     = '0;
                  k_in     = '0;
                  state_in = apsp_pkg::ST_RELAX_RD;
               end
            end
         end
         apsp_pkg::ST_RELAX_RD: begin
            rd_addr_a = {i_ff, k_ff};
            state_in  = apsp_pkg::ST_RELAX_SUM;
         end
         apsp_pkg::ST_RELAX_SUM: begin
            // cell_a holds i->k, cell_b holds k->j; fetch i->j next
            sum_in   = apsp_pkg::sat_sum(cell_a.len, cell_b.len);
            skip_in  = !(cell_a.reach && cell_b.reach);
            state_in = apsp_pkg::ST_RELAX_UPD;
         end
         apsp_pkg::ST_RELAX_UPD: begin
            if (!skip_ff && (!cell_a.reach || sum_ff < cell_a.len)) begin
               wr_en = 1'b1;
            end
            state_in = apsp_pkg::ST_RELAX_RD;
            if (last_j) begin
               j_in = '0;
               if (last_i) begin
                  i_in = '0;
                  if (last_k) begin
                     state_in = apsp_pkg::ST_OUT_RD;
                  end else begin
                     k_in = k_ff + apsp_pkg::IDX_BITS'(1);
                  end
               end else begin
                  i_in = i_ff + apsp_pkg::IDX_BITS'(1);
               end
            end else begin
               j_in = j_ff + apsp_pkg::IDX_BITS'(1);
            end
         end
         apsp_pkg::ST_OUT_RD: begin
            state_in = apsp_pkg::ST_OUT_LD;
         end
         apsp_pkg::ST_OUT_LD: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.distance    = cell_a.reach ? apsp_pkg::out_dist(cell_a.len) : '0;
               rsp_data_in.unreachable = !cell_a.reach;
               rsp_data_in.from_node   = apsp_pkg::NODE_FIELD_BITS'(i_ff);
               rsp_data_in.to_node     = apsp_pkg::NODE_FIELD_BITS'(j_ff);
               rsp_data_in.final_entry = last_i && last_j;
               state_in                = apsp_pkg::ST_OUT_RD;
               if (last_j) begin
                  j_in = '0;
                  if (last_i) begin
                     i_in     = '0;
                     state_in = apsp_pkg::ST_LOAD;
                  end else begin
                     i_in = i_ff + apsp_pkg::IDX_BITS'(1);
                  end
               end else begin
                  j_in = j_ff + apsp_pkg::IDX_BITS'(1);
               end
            end
         end
         default: begin
            state_in = apsp_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= apsp_pkg::ST_LOAD;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      skip_ff     <= skip_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `APSP_ASSERT_IMPLIES(a_wr_state, clock, reset, wr_en, state_ff == apsp_pkg::ST_LOAD || state_ff == apsp_pkg::ST_RELAX_UPD, "matrix written outside load or update")
   `APSP_ASSERT_IMPLIES(a_pop_state, clock, reset, q_pop, state_ff == apsp_pkg::ST_LOAD && !q_empty, "queue popped outside load")
   `APSP_ASSERT_NEXT(a_last_load, clock, reset, q_pop && q_entry.last, state_ff == apsp_pkg::ST_RELAX_RD && i_ff == '0 && j_ff == '0 && k_ff == '0, "relaxation did not start after last entry")
   `APSP_ASSERT_IMPLIES(a_final_corner, clock, reset, rsp_valid_ff && rsp_data_ff.final_entry, 8'(rsp_data_ff.from_node) == 8'(last_idx) && 8'(rsp_data_ff.to_node) == 8'(last_idx), "final result not at last cell")

endmodule

/* src/all_pairs_shortest_path.sv */
// Channel | Ports                              | Direction | Transaction
// req     | req_valid, req_ready, req_data     | in        | one matrix entry, row-major
// rsp     | rsp_valid, rsp_ready, rsp_data     | out       | one distance with its indices
// csr     | csr_valid, csr_ready, csr_data     | in        | node count write, always ready
//
// Loading takes one entry per cycle while the queue has room; the entry that completes
// the matrix starts n^3 relaxations, each a read, a sum and an update state, through the
// single matrix RAM (two read ports, registered read), then n^2 results, each a read and a load state.
// Reset sets the node count to 8 and the load position to 0; the matrix needs no clearing.
// A 4-deep queue absorbs entries during relaxation; req_ready drops when it fills.
// rsp_ready low holds the result register and pauses the output sweep.
module all_pairs_shortest_path (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  apsp_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output apsp_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [apsp_pkg::CFG_BITS-1:0] csr_data
);

   logic                q_push;
   logic                q_pop;
   logic                q_full;
   logic                q_empty;
   apsp_pkg::entry_type push_entry;
   apsp_pkg::entry_type pop_entry;
   apsp_pkg::ctrl_type  ctrl;

   apsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .q_push    (q_push),
      .q_entry   (push_entry),
      .q_full    (q_full),
      .ctrl      (ctrl)
   );

   apsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   apsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .q_empty   (q_empty),
      .q_entry   (pop_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* bench/tb_all_pairs_shortest_path.sv */
`timescale 1ns / 1ps

module tb_all_pairs_shortest_path;

   localparam int SETTLE_CYCLES = 64;
   localparam int PRESS_HOLD    = 300;
   localparam int STALL_LIMIT   = 20000;
   localparam int RANDOM_EDGES  = 175;
   localparam int SLOTS         = apsp_pkg::MAX_NODES * apsp_pkg::MAX_NODES;

   typedef enum logic [1:0] {
      W_SHORT,
      W_MIXED,
      W_ANY,
      W_EXTREME
   } weight_style_type;

   logic                          clock;
   logic                          reset     = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   apsp_pkg::req_type             req_data  = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   apsp_pkg::rsp_type             rsp_data;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [apsp_pkg::CFG_BITS-1:0] csr_data  = '0;

   apsp_pkg::req_type pending_edges[$];
   apsp_pkg::rsp_type expected_paths[$];

   // shadow of the block's matrix, load position and node count
   logic signed [apsp_pkg::DIST_BITS-1:0] path_len [SLOTS];
   logic                                  path_ok  [SLOTS];
   int                                    edges_loaded = 0;
   logic [apsp_pkg::CFG_BITS-1:0]         node_setting = apsp_pkg::NODE_COUNT_RESET;

   int   mismatches  = 0;
   int   send_gap    = 0;
   int   stall_left  = 0;
   int   idle_cycles = 0;
   logic send_burst  = 1'b0;
   logic rsp_burst   = 1'b0;
   logic press_armed = 1'b0;
   logic press_done  = 1'b0;

   all_pairs_shortest_path dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   function automatic int nodes_in_use(logic [apsp_pkg::CFG_BITS-1:0] setting);
      if (setting == 0) return 1;
      if (setting > apsp_pkg::MAX_NODES) return apsp_pkg::MAX_NODES;
      return int'(setting);
   endfunction

   function automatic logic signed [apsp_pkg::DIST_BITS-1:0] clamp_dist(longint v);
      longint top;
      top = (longint'(1) <<< (apsp_pkg::DIST_BITS - 1)) - 1;
      if (v > top) begin
         v = top;
      end else if (v < -top - 1) begin
         v = -top - 1;
      end
      return apsp_pkg::DIST_BITS'(v);
   endfunction

   // Load one matrix entry; the entry that completes the matrix relaxes it and
   // queues every distance in row-major order.
   task automatic absorb_edge(apsp_pkg::req_type e);
      int                                    n;
      int                                    total;
      int                                    slot;
      int                                    ik;
      int                                    kj;
      int                                    ij;
      int                                    k;
      logic signed [apsp_pkg::DIST_BITS-1:0] s;
      apsp_pkg::rsp_type                     want;
      n     = nodes_in_use(node_setting);
      total = n * n;
      if (edges_loaded >= total) edges_loaded = 0;
      slot = (edges_loaded / n) * apsp_pkg::MAX_NODES + edges_loaded % n;
      path_len[slot] = clamp_dist(longint'(e.weight));
      path_ok[slot]  = !e.no_edge;
      edges_loaded++;
      if (edges_loaded < total) return;
      edges_loaded = 0;
      for (int via = 0; via < n; via++) begin
         for (int src = 0; src < n; src++) begin
            for (int dst = 0; dst < n; dst++) begin
               ik = src * apsp_pkg::MAX_NODES + via;
               kj = via * apsp_pkg::MAX_NODES + dst;
               ij = src * apsp_pkg::MAX_NODES + dst;
               // skip paths through a missing edge
               if (path_ok[ik] && path_ok[kj]) begin
                  s = clamp_dist(longint'(path_len[ik]) + longint'(path_len[kj]));
                  if (!path_ok[ij] || s < path_len[ij]) begin
                     path_len[ij] = s;
                     path_ok[ij]  = 1'b1;
                  end
               end
            end
         end
      end
      k = 0;
      for (int src = 0; src < n; src++) begin
         for (int dst = 0; dst < n; dst++) begin
            ij                = src * apsp_pkg::MAX_NODES + dst;
            want.distance     = path_ok[ij] ? path_len[ij] : '0;
            want.unreachable  = !path_ok[ij];
            want.from_node    = 3'(src);
            want.to_node      = 3'(dst);
            want.final_entry  = (k + 1 == total);
            expected_paths.push_back(want);
            k++;
         end
      end
   endtask

   task automatic report_field(string field, logic signed [31:0] want,
                               logic signed [31:0] got);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
   endtask

   task automatic check_path(apsp_pkg::rsp_type got);
      apsp_pkg::rsp_type want;
      if (expected_paths.size() == 0) begin
         $display("%0t: unexpected result, expected none, got %p", $time, got);
         mismatches++;
      end else begin
         want = expected_paths.pop_front();
         if (got.distance !== want.distance)
            report_field("distance", 32'(want.distance), 32'(got.distance));
         if (got.unreachable !== want.unreachable)
            report_field("unreachable", 32'(want.unreachable), 32'(got.unreachable));
         if (got.from_node !== want.from_node)
            report_field("from_node", 32'(want.from_node), 32'(got.from_node));
         if (got.to_node !== want.to_node)
            report_field("to_node", 32'(want.to_node), 32'(got.to_node));
         if (got.final_entry !== want.final_entry)
            report_field("final_entry", 32'(want.final_entry), 32'(got.final_entry));
      end
   endtask

   // driver: present queued entries, predict on each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) absorb_edge(req_data);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_edges.size() != 0) begin
               req_data  <= pending_edges.pop_front();
               req_valid <= 1'b1;
               send_gap = send_burst ? 0 : pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
         if ($urandom_range(0, 99) == 0) send_burst = !send_burst;
      end
   end

   // monitor: check results, stall the result channel at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_path(rsp_data);
            // hold off long once so the input backs up
            if (press_armed && !press_done) begin
               press_done = 1'b1;
               stall_left = PRESS_HOLD;
            end
         end
         if (stall_left == 0 && !rsp_burst && $urandom_range(0, 99) < 25)
            stall_left = pick_gap();
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
         if ($urandom_range(0, 99) == 0) rsp_burst = !rsp_burst;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_edges.size() != 0 || req_valid || expected_paths.size() != 0);
   endtask

   task automatic write_node_count(logic [apsp_pkg::CFG_BITS-1:0] value);
      wait_drained();
      // let the block finish entries still sitting in its queue
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid    <= 1'b0;
      node_setting = value;
      edges_loaded = 0;
      @(negedge clock);
   endtask

   task automatic push_edge(logic signed [15:0] w, logic hole);
      apsp_pkg::req_type e;
      e.weight  = w;
      e.no_edge = hole;
      pending_edges.push_back(e);
   endtask

   function automatic apsp_pkg::req_type make_edge(weight_style_type style, int hole_pct);
      apsp_pkg::req_type e;
      e.no_edge = ($urandom_range(0, 99) < hole_pct);
      case (style)
         W_SHORT: e.weight = 16'($urandom_range(0, 100));
         W_MIXED: e.weight = 16'($urandom_range(0, 140)) - 16'sd40;
         W_ANY:   e.weight = 16'($urandom);
         default: begin
            e.weight = $urandom_range(0, 1) ? 16'sh7fff - 16'($urandom_range(0, 3))
                                            : 16'sh8000 + 16'($urandom_range(0, 3));
         end
      endcase
      return e;
   endfunction

   task automatic run_phase(logic [apsp_pkg::CFG_BITS-1:0] setting, int matrices,
                            int partial, weight_style_type style, int hole_pct,
                            output int queued);
      int total;
      total = nodes_in_use(setting) * nodes_in_use(setting);
      write_node_count(setting);
      queued = matrices * total + partial;
      repeat (queued) pending_edges.push_back(make_edge(style, hole_pct));
   endtask

   initial begin
      int                            r;
      int                            n;
      int                            queued;
      int                            random_edges;
      int                            matrices;
      int                            partial;
      logic [apsp_pkg::CFG_BITS-1:0] setting;
      random_edges = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // partial load under the reset node count, dropped by the next write
      repeat (5) pending_edges.push_back(make_edge(W_ANY, 20));

      write_node_count(apsp_pkg::CFG_BITS'(1));
      push_edge(16'sh7fff, 1'b0);
      push_edge(16'sh8000, 1'b0);
      push_edge(16'sh5a5a, 1'b1);

      write_node_count(apsp_pkg::CFG_BITS'(0));
      push_edge(-16'sd1, 1'b0);

      write_node_count(apsp_pkg::CFG_BITS'(2));
      // sums saturate at the top
      push_edge(16'sd0, 1'b0);
      push_edge(16'sh7fff, 1'b0);
      push_edge(16'sh7fff, 1'b0);
      push_edge(16'sd0, 1'b0);
      // negative cycle, sums saturate at the bottom
      push_edge(16'sh8000, 1'b0);
      push_edge(-16'sd20000, 1'b0);
      push_edge(-16'sd20000, 1'b0);
      push_edge(16'sd0, 1'b0);
      // nothing reachable
      push_edge(16'sh7fff, 1'b1);
      push_edge(16'sh8000, 1'b1);
      push_edge(16'sh0001, 1'b1);
      push_edge(16'shffff, 1'b1);
      // missing diagonal reached through the other node
      push_edge(16'sd0, 1'b1);
      push_edge(16'sd5, 1'b0);
      push_edge(16'sd7, 1'b0);
      push_edge(16'sd0, 1'b1);

      wait_drained();
      press_armed = 1'b1;
      run_phase(apsp_pkg::CFG_BITS'(3), 3, 0, W_SHORT, 20, queued);
      random_edges += queued;
      run_phase(apsp_pkg::CFG_BITS'(8), 1, 0, W_MIXED, 30, queued);
      random_edges += queued;
      run_phase(apsp_pkg::CFG_BITS'(15), 1, 0, W_ANY, 10, queued);
      random_edges += queued;

      while (random_edges < RANDOM_EDGES) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            setting = apsp_pkg::CFG_BITS'($urandom_range(1, 3));
         end else if (r < 75) begin
            setting = apsp_pkg::CFG_BITS'($urandom_range(4, 6));
         end else if (r < 85) begin
            setting = apsp_pkg::CFG_BITS'($urandom_range(7, 8));
         end else if (r < 90) begin
            setting = '0;
         end else begin
            setting = apsp_pkg::CFG_BITS'($urandom_range(9, 15));
         end
         n        = nodes_in_use(setting);
         matrices = (n > 6) ? 1 : $urandom_range(1, 3);
         // now and then leave a load unfinished before the next write
         partial  = (n > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, n * n - 1) : 0;
         run_phase(setting, matrices, partial, weight_style_type'($urandom_range(0, 3)),
                   $urandom_range(0, 50), queued);
         random_edges += queued;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
